@@ rtl/modular_exponentiation_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the modular exponentiation core.
// Both macros sample on clk and are disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_CORE_ASSERT_SVH
`define MODULAR_EXPONENTIATION_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MEC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MEC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/mexp_pkg.sv @@
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared types and constants of the modular exponentiation core.
// ----------------------------------------------------------------------------
package mexp_pkg;

	// Width of the slice of the product held by one cell.
	localparam int CELL_BITS = 8;

	// Configuration port geometry.
	localparam int APB_DATA_BITS = 64;
	localparam int APB_ADDR_BITS = 4;

	// Register index, taken from address bit 3 (registers lie 8 bytes apart).
	localparam logic REG_EXPONENT = 1'b0;
	localparam logic REG_MODULUS  = 1'b1;

	// Signals handed from one cell to the next higher one.
	typedef struct packed {
		logic dbl_bit;  // top bit of the product slice, shifted up when doubling
		logic borrow1;  // borrow of (2p - m)
		logic carry2;   // carry of (r1 + addend)
		logic borrow2;  // borrow of (s2 - m)
	} cell_link_t;

endpackage

@@ rtl/mexp_cell.sv @@
// ----------------------------------------------------------------------------
// mexp_cell
// One slice of the bit-serial modular multiplier: holds CELL_BITS bits of
// the partial product and does one double-and-add step with reduction.
// ----------------------------------------------------------------------------
module mexp_cell import mexp_pkg::*; (
	input  logic                 clk,
	input  logic                 clr,
	input  logic                 en,
	input  logic                 sel1,
	input  logic                 sel2,
	input  logic                 add_en,
	input  logic [CELL_BITS-1:0] a_slice,
	input  logic [CELL_BITS-1:0] m_slice,
	input  cell_link_t           link_in,
	output cell_link_t           link_out,
	output logic [CELL_BITS-1:0] p_slice
);

	logic [CELL_BITS-1:0] p_q;
	logic [CELL_BITS-1:0] dbl;
	logic [CELL_BITS-1:0] r1;
	logic [CELL_BITS-1:0] addend;
	logic [CELL_BITS-1:0] s2;
	logic [CELL_BITS-1:0] r2;
	logic [CELL_BITS:0]   diff1;
	logic [CELL_BITS:0]   sum2;
	logic [CELL_BITS:0]   diff2;

	// Double the product, then conditionally subtract the modulus.
	assign dbl   = {p_q[CELL_BITS-2:0], link_in.dbl_bit};
	assign diff1 = {1'b0, dbl} - {1'b0, m_slice} - {{CELL_BITS{1'b0}}, link_in.borrow1};
	assign r1    = sel1 ? diff1[CELL_BITS-1:0] : dbl;

	// Add the multiplicand when the multiplier bit is set, then reduce again.
	assign addend = add_en ? a_slice : '0;
	assign sum2   = {1'b0, r1} + {1'b0, addend} + {{CELL_BITS{1'b0}}, link_in.carry2};
	assign s2     = sum2[CELL_BITS-1:0];
	assign diff2  = {1'b0, s2} - {1'b0, m_slice} - {{CELL_BITS{1'b0}}, link_in.borrow2};
	assign r2     = sel2 ? diff2[CELL_BITS-1:0] : s2;

	// Chain outputs to the next cell.
	assign link_out.dbl_bit = p_q[CELL_BITS-1];
	assign link_out.borrow1 = diff1[CELL_BITS];
	assign link_out.carry2  = sum2[CELL_BITS];
	assign link_out.borrow2 = diff2[CELL_BITS];

	// Product slice register.
	always_ff @(posedge clk) begin
		if (clr) begin
			p_q <= '0;
		end else if (en) begin
			p_q <= r2;
		end
	end

	assign p_slice = p_q;

endmodule

@@ rtl/modular_exponentiation_core.sv @@
// ----------------------------------------------------------------------------
// modular_exponentiation_core
// Computes message_value ^ exponent mod modulus by right-to-left square and
// multiply, each modular product formed bit-serially on a row of cells.
//
// Channel  | Direction | Handshake                    | Payload
// ---------+-----------+------------------------------+---------------
// command  | in        | start high while busy is low | message_value
// result   | out       | done strobe, one cycle       | power_result
// config   | in/out    | APB write/read, pready = 1   | exponent, modulus
//
// The multiplier row covers WORD_BITS rounded up to a whole number of 8-bit
// cells; it consumes one multiplier bit per cycle and runs one reduction,
// then a multiply and a square per exponent bit.
// One item is in flight at a time; busy stays high until done is pulsed.
// Reset clears the control state and sets both registers to one.
// The receiver cannot stall the result.
// ----------------------------------------------------------------------------
module modular_exponentiation_core import mexp_pkg::*; #(
	parameter int WORD_BITS = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [WORD_BITS-1:0]     message_value,
	output logic                     done,
	output logic [WORD_BITS-1:0]     power_result,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_ADDR_BITS-1:0] paddr,
	input  logic [APB_DATA_BITS-1:0] pwdata,
	output logic [APB_DATA_BITS-1:0] prdata,
	output logic                     pready
);

	localparam int NCELLS = (WORD_BITS + CELL_BITS - 1) / CELL_BITS;
	localparam int NW     = NCELLS * CELL_BITS;
	localparam int CW     = $clog2(NW);
	localparam int RW     = $clog2(WORD_BITS);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_WB   = 3'b100
	} state_t;

	typedef enum logic [1:0] {
		OP_REDUCE,
		OP_MULT,
		OP_SQUARE
	} op_t;

	state_t                 state_q;
	op_t                    op_q;
	logic [WORD_BITS-1:0]   exp_q;
	logic [WORD_BITS-1:0]   mod_q;
	logic [WORD_BITS-1:0]   ebits_q;
	logic [NW-1:0]          base_q;
	logic [NW-1:0]          acc_q;
	logic [NW-1:0]          a_q;
	logic [NW-1:0]          b_q;
	logic [CW-1:0]          cnt_q;
	logic [RW-1:0]          round_q;
	logic                   done_q;
	logic [WORD_BITS-1:0]   result_q;

	logic                   accept;
	logic                   cfg_wr;
	logic                   cell_clr;
	logic                   sel1;
	logic                   sel2;
	logic [NW-1:0]          mod_pad;
	logic [NW-1:0]          prod;
	logic [NW-1:0]          one_w;
	cell_link_t             link [NCELLS+1];

	assign accept  = start && (state_q == ST_IDLE);
	assign busy    = (state_q != ST_IDLE);
	assign done    = done_q;
	assign power_result = result_q;
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign mod_pad = NW'(mod_q);

	// Residue of one: zero for a modulus of one.
	assign one_w = (mod_q == WORD_BITS'(1)) ? '0 : NW'(1);

	// Cells are cleared whenever a new product begins.
	assign cell_clr = accept || ((state_q == ST_WB) &&
		!((op_q == OP_SQUARE) && (round_q == RW'(WORD_BITS - 1))));

	// Row of multiplier cells.
	assign link[0] = '0;
	for (genvar i = 0; i < NCELLS; i++) begin : g_cell
		mexp_cell u_cell (
			.clk      (clk),
			.clr      (cell_clr),
			.en       (state_q == ST_RUN),
			.sel1     (sel1),
			.sel2     (sel2),
			.add_en   (b_q[NW-1]),
			.a_slice  (a_q[i*CELL_BITS +: CELL_BITS]),
			.m_slice  (mod_pad[i*CELL_BITS +: CELL_BITS]),
			.link_in  (link[i]),
			.link_out (link[i+1]),
			.p_slice  (prod[i*CELL_BITS +: CELL_BITS])
		);
	end

	// Reduce when the widened value reaches the modulus.
	assign sel1 = link[NCELLS].dbl_bit | ~link[NCELLS].borrow1;
	assign sel2 = link[NCELLS].carry2  | ~link[NCELLS].borrow2;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q <= WORD_BITS'(1);
			mod_q <= WORD_BITS'(1);
		end else if (cfg_wr) begin
			unique case (paddr[3])
				REG_EXPONENT: exp_q <= pwdata[WORD_BITS-1:0];
				REG_MODULUS:  mod_q <= pwdata[WORD_BITS-1:0];
				default:      exp_q <= exp_q;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		unique case (paddr[3])
			REG_EXPONENT: prdata = APB_DATA_BITS'(exp_q);
			REG_MODULUS:  prdata = APB_DATA_BITS'(mod_q);
			default:      prdata = '0;
		endcase
	end

	// Sequencer: reduce the base, then one multiply and one square per bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_REDUCE;
			cnt_q   <= '0;
			round_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_RUN;
						op_q    <= OP_REDUCE;
						cnt_q   <= '0;
						round_q <= '0;
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(NW - 1)) begin
						state_q <= ST_WB;
					end
				end
				ST_WB: begin
					cnt_q <= '0;
					unique case (op_q)
						OP_REDUCE: begin
							op_q    <= OP_MULT;
							state_q <= ST_RUN;
						end
						OP_MULT: begin
							op_q    <= OP_SQUARE;
							state_q <= ST_RUN;
						end
						default: begin
							round_q <= round_q + RW'(1);
							if (round_q == RW'(WORD_BITS - 1)) begin
								state_q <= ST_IDLE;
								done_q  <= 1'b1;
							end else begin
								op_q    <= OP_MULT;
								state_q <= ST_RUN;
							end
						end
					endcase
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Operand and value registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			a_q     <= one_w;
			b_q     <= NW'(message_value);
			acc_q   <= one_w;
			ebits_q <= exp_q;
		end else if (state_q == ST_RUN) begin
			b_q <= {b_q[NW-2:0], 1'b0};
		end else if (state_q == ST_WB) begin
			case (op_q)
				OP_REDUCE: begin
					base_q <= prod;
					a_q    <= acc_q;
					b_q    <= prod;
				end
				OP_MULT: begin
					if (ebits_q[0]) begin
						acc_q <= prod;
					end
					a_q <= base_q;
					b_q <= base_q;
				end
				default: begin
					base_q   <= prod;
					ebits_q  <= {1'b0, ebits_q[WORD_BITS-1:1]};
					a_q      <= acc_q;
					b_q      <= prod;
					result_q <= acc_q[WORD_BITS-1:0];
				end
			endcase
		end
	end

	`include "modular_exponentiation_core_assert.svh"

	`MEC_ASSERT_SAME(a_done_idle, done, !busy, "result strobed while busy")
	`MEC_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not start")
	`MEC_ASSERT_NEXT(a_wb_single, state_q == ST_WB, state_q != ST_WB, "write-back longer than one cycle")
	`MEC_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe longer than one cycle")

endmodule

@@ verif/modular_exponentiation_core_tb.sv @@
// ----------------------------------------------------------------------------
// modular_exponentiation_core_tb
// Self-checking testbench of the modular exponentiation core. Message values
// are issued through the start/busy command port, exponent and modulus are
// set over APB while the core is idle, and every power_result is compared
// with a square-and-multiply computation done here at full width.
// ----------------------------------------------------------------------------
module modular_exponentiation_core_tb import mexp_pkg::*;;

	localparam int WB = 64;
	localparam logic [APB_ADDR_BITS-1:0] ADDR_EXPONENT = {REG_EXPONENT, 3'b000};
	localparam logic [APB_ADDR_BITS-1:0] ADDR_MODULUS  = {REG_MODULUS, 3'b000};

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic [WB-1:0]            message_value;
	logic                     done;
	logic [WB-1:0]            power_result;
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [APB_ADDR_BITS-1:0] paddr;
	logic [APB_DATA_BITS-1:0] pwdata;
	logic [APB_DATA_BITS-1:0] prdata;
	logic                     pready;

	// Local copy of the key registers and the expected powers in issue order.
	logic [WB-1:0] key_exponent;
	logic [WB-1:0] key_modulus;
	logic [WB-1:0] expected_powers[$];
	int            error_count;
	bit            gaps_on;

	modular_exponentiation_core #(.WORD_BITS(WB)) u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.message_value(message_value), .done(done), .power_result(power_result),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Runaway guard: far beyond the slowest legal run.
	initial begin
		#20000000;
		$display("status: fail");
		$finish;
	end

	// Square-and-multiply from the least significant exponent bit, reducing
	// after every product; a zero modulus means plain wrapping arithmetic.
	function automatic logic [WB-1:0] mod_power(logic [WB-1:0] base_in,
			logic [WB-1:0] pow, logic [WB-1:0] m);
		logic [WB-1:0]   base;
		logic [WB-1:0]   acc;
		logic [2*WB-1:0] prod;
		base = (m != 0) ? base_in % m : base_in;
		acc  = (m != 0) ? 64'd1 % m : 64'd1;
		for (int i = 0; i < WB; i++) begin
			if (pow[i]) begin
				prod = acc * base;
				acc = (m != 0) ? prod % m : prod[WB-1:0];
			end
			prod = base * base;
			base = (m != 0) ? prod % m : prod[WB-1:0];
		end
		return acc;
	endfunction

	function automatic logic [WB-1:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	// Result checker: every done strobe must match the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_powers.size() == 0) begin
				$error("power_result: unexpected result %h", power_result);
				error_count++;
			end else begin
				if (power_result !== expected_powers[0]) begin
					$error("power_result: expected %h, actual %h",
						expected_powers[0], power_result);
					error_count++;
				end
				void'(expected_powers.pop_front());
			end
		end
	end

	// Issue one message value and record the power it should produce.
	task automatic send_message(logic [WB-1:0] value);
		@(posedge clk);
		start <= 1'b1;
		message_value <= value;
		do @(posedge clk); while (busy);
		expected_powers.push_back(mod_power(value, key_exponent, key_modulus));
		start <= 1'b0;
		if (gaps_on && $urandom_range(0, 1))
			repeat ($urandom_range(1, 15)) @(posedge clk);
	endtask

	// Wait until every issued item has produced its result.
	task automatic wait_idle();
		while (expected_powers.size() != 0 || busy)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// APB write: setup cycle, then access cycle.
	task automatic apb_write(logic [APB_ADDR_BITS-1:0] addr, logic [WB-1:0] data);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_key(logic [WB-1:0] pow, logic [WB-1:0] m);
		wait_idle();
		apb_write(ADDR_EXPONENT, pow);
		apb_write(ADDR_MODULUS, m);
		key_exponent = pow;
		key_modulus = m;
	endtask

	// Both registers reset to one, so every result is zero.
	task automatic test_reset_keys();
		send_message(64'd0);
		send_message(64'd12345);
		send_message('1);
	endtask

	// Exponent zero gives one, or zero with modulus one.
	task automatic test_exponent_zero();
		set_key(64'd0, 64'd97);
		send_message(64'd0);
		send_message(64'd5);
		set_key(64'd0, 64'd1);
		send_message(64'd7);
	endtask

	// Modulus one with a full exponent still gives zero.
	task automatic test_modulus_one();
		set_key('1, 64'd1);
		send_message('1);
		send_message(64'd3);
	endtask

	// Field extremes, bases at and above the modulus, a small textbook key pair.
	task automatic test_extremes();
		set_key('1, '1);
		send_message(64'd0);
		send_message(64'd1);
		send_message('1);
		send_message(64'hFFFF_FFFF_FFFF_FFFE);
		set_key(64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFC5);
		send_message(64'd2);
		send_message(64'h5555_5555_5555_5555);
		set_key(64'd17, 64'd3233);
		send_message(64'd65);
		send_message(64'd3233);
		send_message(64'd6466);
		set_key(64'd2753, 64'd3233);
		send_message(64'd2790);
		set_key(64'd2, 64'd2);
		send_message(64'd3);
		send_message(64'hAAAA_AAAA_AAAA_AAAA);
	endtask

	// Random keys and random message values, mostly below the modulus.
	task automatic test_random_keys(int keys, int per_key);
		logic [WB-1:0] m;
		logic [WB-1:0] v;
		for (int k = 0; k < keys; k++) begin
			m = rand_word() >> $urandom_range(0, 60);
			if (m == 0)
				m = 64'd1;
			set_key(rand_word() >> $urandom_range(0, 63), m);
			for (int n = 0; n < per_key; n++) begin
				v = rand_word();
				if ($urandom_range(0, 3) != 0)
					v = v % m;
				send_message(v);
			end
		end
	endtask

	// Stimulus sequence.
	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		message_value = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		error_count = 0;
		gaps_on = 1'b1;
		key_exponent = 64'd1;
		key_modulus = 64'd1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_keys();
		test_exponent_zero();
		test_modulus_one();
		test_extremes();
		test_random_keys(4, 20);
		gaps_on = 1'b0;
		test_random_keys(1, 20);

		wait_idle();
		repeat (20) @(posedge clk);
		if (error_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
